[sv/aaq_pkg.sv]
package aaq_pkg;

    // result format
    localparam int OUT_FRAC_BITS = 14;
    localparam int OUT_W         = OUT_FRAC_BITS + 2;
    localparam logic [63:0] OUT_ONE = 64'd1 << OUT_FRAC_BITS;

    // CORDIC
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;

    // atan(2^-i), 2^32 units per turn
    localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // result word
    typedef struct packed {
        logic [OUT_W-1:0] qx;
        logic [OUT_W-1:0] qy;
        logic [OUT_W-1:0] qz;
        logic [OUT_W-1:0] qw;
        logic             zero;
    } t_res;

    // inverse CORDIC gain, Q30, for a given step count
    function automatic longint cordic_gain(input int steps);
        int n;
        int s;
        n = steps;
        if (n > MAX_STEPS) n = MAX_STEPS;
        if (n < 1) n = 1;
        s = 2 * n;
        return 64'sd652032874 + ((64'sd434688583 + (64'sd1 <<< (s - 1))) >>> s);
    endfunction

    // round half away from zero, drop 'shift' bits, clamp to +-1
    function automatic logic [OUT_W-1:0] to_out(input logic signed [63:0] v,
                                                 input int shift);
        logic        neg;
        logic [63:0] m;
        neg = v[63];
        m   = neg ? 64'(-v) : 64'(v);
        if (shift > 0) m = (m + (64'd1 << (shift - 1))) >> shift;
        if (m > OUT_ONE) m = OUT_ONE;
        if (neg) m = 64'(-m);
        return m[OUT_W-1:0];
    endfunction

endpackage

[sv/aaq_in_if.sv]
interface aaq_in_if;
    import aaq_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [17:0] angle;

    modport source (output valid, axis_x, axis_y, axis_z, angle, input ready);
    modport sink   (input valid, axis_x, axis_y, axis_z, angle, output ready);
endinterface

[sv/aaq_out_if.sv]
interface aaq_out_if;
    import aaq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] quat_x;
    logic signed [OUT_W-1:0] quat_y;
    logic signed [OUT_W-1:0] quat_z;
    logic signed [OUT_W-1:0] quat_w;
    logic                    axis_zero;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, axis_zero, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, axis_zero, output ready);
endinterface

[sv/aaq_skid.sv]
module aaq_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  aaq_pkg::t_res i_res,
    output logic          o_room,
    aaq_out_if.source     o_quat
);
    import aaq_pkg::*;

    // two-word output queue, head drives the port
    logic [1:0] r_cnt, n_cnt;
    t_res       r_head, r_tail;
    logic       pop;

    assign pop    = (r_cnt != 2'd0) && o_quat.ready;
    assign o_room = (r_cnt != 2'd2);
    assign n_cnt  = 2'(r_cnt + {1'b0, i_push} - {1'b0, pop});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_cnt == 2'd2) begin
            r_head <= r_tail;
        end
        if (i_push) begin
            if (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)) begin
                r_head <= i_res;
            end else begin
                r_tail <= i_res;
            end
        end
    end

    assign o_quat.valid     = (r_cnt != 2'd0);
    assign o_quat.quat_x    = r_head.qx;
    assign o_quat.quat_y    = r_head.qy;
    assign o_quat.quat_z    = r_head.qz;
    assign o_quat.quat_w    = r_head.qw;
    assign o_quat.axis_zero = r_head.zero;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("skid count out of range");
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 2'd2) else $error("push into full skid");
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !o_quat.ready) |=> r_cnt == 2'd2)
        else $error("full skid lost a word");
`endif

endmodule

[sv/axis_angle_to_quaternion.sv]
// Channel   Dir  Ready meaning                 Word
// i_item    in   pipeline advancing            axis_x, axis_y, axis_z, angle
// o_quat    out  sink takes head of out queue  quat_x/y/z/w (Q1.14), axis_zero
//
// One word in per cycle while the out queue has room. Stages: input register,
// squares, sum, a 32-step root, a 31-step divider, multiply, round, out queue.
// The root and divider chains set the depth; CORDIC runs beside the root.
// Synchronous active-low reset clears valid bits and the out queue count.
// A full out queue freezes the whole pipeline; no word is lost or repeated.
module axis_angle_to_quaternion #(
    parameter int CORDIC_STEPS = aaq_pkg::CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aaq_in_if.sink    i_item,
    aaq_out_if.source o_quat
);
    import aaq_pkg::*;

    // stage map
    localparam int SQ_B = 3;          // root steps start
    localparam int SQ_N = 32;
    localparam int CB   = 3;          // CORDIC steps start, beside root
    localparam int DV_B = SQ_B + SQ_N; // divider steps start, sign flip here
    localparam int DV_N = 31;
    localparam int MUL  = DV_B + DV_N;
    localparam int RND  = MUL + 1;
    localparam int NS   = RND + 1;

    localparam logic signed [33:0] GAIN = 34'(cordic_gain(CORDIC_STEPS));

    typedef struct packed {
        logic [2:0][15:0]  ax;
        logic [2:0][15:0]  am;
        logic [2:0][31:0]  sqr;
        logic [31:0]       sq;
        logic              zero;
        logic [31:0]       root;   // becomes Q16 length
        logic [33:0]       srem;
        logic [2:0][31:0]  drem;
        logic [2:0][30:0]  quo;    // unit axis magnitude, Q30
        logic signed [33:0] x;     // cos, Q30
        logic signed [33:0] y;     // sin, Q30
        logic signed [32:0] z;
        logic              flip;
        logic [2:0][63:0]  prod;
        t_res              res;
    } t_stage;

    t_stage          r_st [NS];
    t_stage          n_st [NS];
    logic [NS-1:0]   r_v;
    logic            en;
    logic            room;

    assign en           = room;
    assign i_item.ready = en;

    // stage 0: capture, angle fold, abs values
    always_comb begin
        logic [31:0] ph;
        logic        fl;
        n_st[0] = '0;
        n_st[0].ax = {i_item.axis_z, i_item.axis_y, i_item.axis_x};
        for (int i = 0; i < 3; i++) begin
            n_st[0].am[i]   = n_st[0].ax[i][15] ? 16'(-n_st[0].ax[i]) : n_st[0].ax[i];
            n_st[0].drem[i] = {1'b0, n_st[0].am[i], 15'b0};
        end
        // half angle, 2^32 units per turn; fold quadrants 1 and 2
        ph = {i_item.angle[16:0], 15'b0};
        fl = ph[31] ^ ph[30];
        n_st[0].flip = fl;
        n_st[0].z    = $signed({ph[31] ^ fl, ph[31] ^ fl, ph[30:0]});
        n_st[0].x    = GAIN;
        n_st[0].y    = '0;
    end

    genvar j;
    generate
        for (j = 1; j < NS; j++) begin : g_stage
            t_stage             p;
            logic signed [33:0] g_x, g_y;
            logic signed [32:0] g_z;
            logic [31:0]        g_root;
            logic [33:0]        g_srem;
            logic [2:0][31:0]   g_drem;
            logic [2:0][30:0]   g_quo;

            assign p = r_st[j-1];

            // CORDIC rotation step
            if (j >= CB && j < CB + CORDIC_STEPS) begin : g_cor
                localparam int I = j - CB;
                localparam logic signed [32:0] AT = $signed({1'b0, ATAN_TAB[I]});
                always_comb begin
                    logic signed [33:0] dx, dy;
                    dx = p.y >>> I;
                    dy = p.x >>> I;
                    if (!p.z[32]) begin
                        g_x = p.x - dx;
                        g_y = p.y + dy;
                        g_z = p.z - AT;
                    end else begin
                        g_x = p.x + dx;
                        g_y = p.y - dy;
                        g_z = p.z + AT;
                    end
                end
            end else begin : g_cor_pass
                assign g_x = p.x;
                assign g_y = p.y;
                assign g_z = p.z;
            end

            // root: one result bit per stage
            if (j >= SQ_B && j < SQ_B + SQ_N) begin : g_sqrt
                localparam int K = j - SQ_B;
                always_comb begin
                    logic [63:0] v;
                    logic [35:0] rem, trial;
                    v     = {p.sq, 32'b0};
                    rem   = {p.srem, v[63-2*K -: 2]};
                    trial = {2'b0, p.root, 2'b01};
                    if (rem >= trial) begin
                        g_srem = 34'(rem - trial);
                        g_root = {p.root[30:0], 1'b1};
                    end else begin
                        g_srem = rem[33:0];
                        g_root = {p.root[30:0], 1'b0};
                    end
                end
            end else begin : g_sqrt_pass
                assign g_srem = p.srem;
                assign g_root = p.root;
            end

            // divider: one quotient bit per stage, three lanes
            if (j >= DV_B && j < DV_B + DV_N) begin : g_div
                localparam int K = j - DV_B;
                always_comb begin
                    logic [32:0] r2;
                    g_quo = p.quo;
                    for (int i = 0; i < 3; i++) begin
                        r2 = {p.drem[i], 1'b0};
                        if (r2 >= {1'b0, p.root}) begin
                            g_drem[i]         = 32'(r2 - {1'b0, p.root});
                            g_quo[i][30 - K]  = 1'b1;
                        end else begin
                            g_drem[i] = r2[31:0];
                        end
                    end
                end
            end else begin : g_div_pass
                assign g_drem = p.drem;
                assign g_quo  = p.quo;
            end

            always_comb begin
                logic signed [31:0] u, s;
                logic signed [63:0] pr;
                n_st[j] = p;
                n_st[j].x    = g_x;
                n_st[j].y    = g_y;
                n_st[j].z    = g_z;
                n_st[j].root = g_root;
                n_st[j].srem = g_srem;
                n_st[j].drem = g_drem;
                n_st[j].quo  = g_quo;
                if (j == 1) begin
                    for (int i = 0; i < 3; i++) begin
                        n_st[j].sqr[i] = 32'($signed(p.ax[i]) * $signed(p.ax[i]));
                    end
                end
                if (j == 2) begin
                    n_st[j].sq   = p.sqr[0] + p.sqr[1] + p.sqr[2];
                    n_st[j].zero = (p.sqr[0] == '0) && (p.sqr[1] == '0) && (p.sqr[2] == '0);
                end
                if (j == DV_B && p.flip) begin
                    n_st[j].x = -p.x;
                    n_st[j].y = -p.y;
                end
                if (j == MUL) begin
                    s = $signed(p.y[31:0]);
                    for (int i = 0; i < 3; i++) begin
                        u  = p.ax[i][15] ? -$signed({1'b0, p.quo[i]})
                                         : $signed({1'b0, p.quo[i]});
                        pr = u * s;   // Q60
                        n_st[j].prod[i] = pr;
                    end
                end
                if (j == RND) begin
                    n_st[j].res.qx   = p.zero ? '0 : to_out($signed(p.prod[0]), 60 - OUT_FRAC_BITS);
                    n_st[j].res.qy   = p.zero ? '0 : to_out($signed(p.prod[1]), 60 - OUT_FRAC_BITS);
                    n_st[j].res.qz   = p.zero ? '0 : to_out($signed(p.prod[2]), 60 - OUT_FRAC_BITS);
                    n_st[j].res.qw   = to_out(64'(p.x), 30 - OUT_FRAC_BITS);
                    n_st[j].res.zero = p.zero;
                end
            end
        end
    endgenerate

    // stage registers: payload unreset, valid bits reset
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], i_item.valid};
        end
    end

    aaq_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && r_v[NS-1]),
        .i_res   (r_st[NS-1].res),
        .o_room  (room),
        .o_quat  (o_quat)
    );

`ifndef SYNTHESIS
    localparam logic signed [OUT_W-1:0] S_ONE  = OUT_W'(OUT_ONE);
    localparam logic signed [OUT_W-1:0] S_MONE = OUT_W'(-OUT_ONE);

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v)) else $error("frozen pipeline moved");
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_quat.valid && o_quat.axis_zero) |->
        (o_quat.quat_x == '0 && o_quat.quat_y == '0 && o_quat.quat_z == '0))
        else $error("zero axis with nonzero vector part");
    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> ($signed(o_quat.quat_w) <= S_ONE &&
                          $signed(o_quat.quat_w) >= S_MONE))
        else $error("scalar part beyond one");
`endif

endmodule

[dv/aaq_checker.sv]
`timescale 1ns / 1ps

module aaq_checker
    import aaq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    aaq_in_if         i_item,
    aaq_out_if        o_quat,
    output int        o_fail_count,
    output int        o_pending
);

    localparam longint FULL_TURN = 64'sd4294967296;

    t_res quat_expected[$];

    function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v,
                                                      input int sh);
        return v >>> sh;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r    = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] round_sat(input logic signed [63:0] v,
                                                   input int sh);
        logic        neg;
        logic [63:0] m;
        neg = v < 0;
        m   = neg ? 64'(-v) : 64'(v);
        m   = (m + (64'd1 << (sh - 1))) >> sh;
        if (m > (64'd1 << OUT_FRAC_BITS)) m = 64'd1 << OUT_FRAC_BITS;
        if (neg) m = 64'(-m);
        return m[OUT_W-1:0];
    endfunction

    function automatic t_res quat_from_axis_angle(input logic signed [15:0] ax,
                                                  input logic signed [15:0] ay,
                                                  input logic signed [15:0] az,
                                                  input logic [17:0] ang);
        t_res                 r;
        logic signed [63:0]   comp [3];
        logic [63:0]          sq;
        logic [63:0]          ph;
        logic [63:0]          mag;
        logic [63:0]          am;
        logic signed [63:0]   z, x, y, dx, dy, c, s, u;
        logic                 flip;
        int                   n, steps;
        comp[0] = ax;
        comp[1] = ay;
        comp[2] = az;
        sq = 0;
        for (int i = 0; i < 3; i++) sq += 64'(comp[i] * comp[i]);
        ph   = {32'd0, ang[16:0], 15'd0};
        flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
        if (flip) ph = (ph - 64'h8000_0000) & 64'hFFFF_FFFF;
        z = (ph >= 64'h8000_0000) ? $signed(ph) - FULL_TURN : $signed(ph);
        steps = CORDIC_STEPS_DEF;
        n     = 2 * steps;
        x = 64'sd652032874 + ((64'sd434688583 + (64'sd1 <<< (n - 1))) >>> n);
        y = 0;
        for (int i = 0; i < steps; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - $signed({32'd0, ATAN_TAB[i]});
            end else begin
                x = x + dx; y = y - dy; z = z + $signed({32'd0, ATAN_TAB[i]});
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        if (sq == 0) begin
            r.qx = '0; r.qy = '0; r.qz = '0; r.zero = 1'b1;
        end else begin
            mag = int_sqrt(sq << 32);
            for (int i = 0; i < 3; i++) begin
                am = comp[i] < 0 ? 64'(-comp[i]) : 64'(comp[i]);
                u  = $signed((am << 46) / mag);
                if (comp[i] < 0) u = -u;
                case (i)
                    0: r.qx = round_sat(u * s, 60 - OUT_FRAC_BITS);
                    1: r.qy = round_sat(u * s, 60 - OUT_FRAC_BITS);
                    default: r.qz = round_sat(u * s, 60 - OUT_FRAC_BITS);
                endcase
            end
            r.zero = 1'b0;
        end
        r.qw = round_sat(c, 30 - OUT_FRAC_BITS);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res exp_q;
        t_res got_q;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_item.valid && i_item.ready)
                quat_expected.push_back(quat_from_axis_angle(i_item.axis_x, i_item.axis_y,
                                                             i_item.axis_z, i_item.angle));
            if (o_quat.valid && o_quat.ready) begin
                got_q = '{o_quat.quat_x, o_quat.quat_y, o_quat.quat_z, o_quat.quat_w,
                          o_quat.axis_zero};
                if (quat_expected.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got_q);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_q = quat_expected.pop_front();
                    if (exp_q !== got_q) begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d zero=%0b",
                                 $time, $signed(exp_q.qx), $signed(exp_q.qy),
                                 $signed(exp_q.qz), $signed(exp_q.qw), exp_q.zero);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d zero=%0b",
                                 $time, $signed(got_q.qx), $signed(got_q.qy),
                                 $signed(got_q.qz), $signed(got_q.qw), got_q.zero);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= quat_expected.size();
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import aaq_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;   // chance of an empty cycle on the input side
    int   sink_stall_pct;  // chance of a stall cycle on the output side
    int   hold_cycles;     // when nonzero, sink holds ready low this many cycles

    aaq_in_if  item_if ();
    aaq_out_if quat_if ();

    axis_angle_to_quaternion dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if.sink),
        .o_quat  (quat_if.source)
    );

    aaq_checker quat_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_if),
        .o_quat       (quat_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random stalls, plus a long hold-off when asked for.
    initial begin
        quat_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                quat_if.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                quat_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Offer one word; idle cycles are inserted ahead of it at random.
    task automatic send_word(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input logic [17:0] ang);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid  <= 1'b1;
        item_if.axis_x <= ax;
        item_if.axis_y <= ay;
        item_if.axis_z <= az;
        item_if.angle  <= ang;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random;
        logic [15:0] c [3];
        logic [17:0] ang;
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(5))
                0:       c[i] = 16'($urandom_range(3) - 1);  // tiny, incl. zero
                1:       c[i] = $urandom_range(1) ? 16'h8000 : 16'h7fff;
                default: c[i] = 16'($urandom);
            endcase
        end
        if ($urandom_range(19) == 0) c = '{16'd0, 16'd0, 16'd0};
        case ($urandom_range(7))
            0:       ang = 18'(($urandom_range(7)) << 14);  // quadrant edges
            default: ang = 18'($urandom);
        endcase
        send_word(c[0], c[1], c[2], ang);
    endtask

    task automatic drain;
        item_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        item_if.valid  = 1'b0;
        item_if.axis_x = '0;
        item_if.axis_y = '0;
        item_if.axis_z = '0;
        item_if.angle  = '0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_cycles    = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero axis, unit axes, extremes, quadrant edges, wrap
        send_word(16'd0, 16'd0, 16'd0, 18'd0);
        send_word(16'd0, 16'd0, 16'd0, 18'd32768);
        send_word(16'd1, 16'd0, 16'd0, 18'd16384);
        send_word(16'd0, 16'hffff, 16'd0, 18'd16384);
        send_word(16'd0, 16'd0, 16'h7fff, 18'd32768);
        send_word(16'h8000, 16'h8000, 16'h8000, 18'd65535);
        send_word(16'h7fff, 16'h7fff, 16'h7fff, 18'h3ffff);
        send_word(16'h8000, 16'd0, 16'd0, 18'h20000);
        send_word(16'h7fff, 16'h8000, 16'd1, 18'h1ffff);
        send_word(16'd3, 16'd4, 16'd0, 18'd49152);
        send_word(16'd1, 16'd1, 16'd1, 18'd16383);
        send_word(16'hffff, 16'hffff, 16'hffff, 18'd16385);
        send_word(16'd5, 16'd0, 16'd0, 18'd65536);   // one full turn: half turn
        send_word(16'd5, 16'd0, 16'd0, 18'd98304);
        send_word(16'h5555, 16'haaaa, 16'h1234, 18'h2aaaa);
        send_word(16'd0, 16'd0, 16'd0, 18'h15555);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 35 : 0;
            sink_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 35 : 0;
            if (ph == 2) hold_cycles = 300;  // long hold-off: pipeline fills and stalls input
            for (int n = 0; n < 170; n++) send_random();
            if (ph == 1) drain();            // sender pauses until all results are in
        end

        drain();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0)
            $display("axis_angle_to_quaternion verification clean");
        else
            $display("axis_angle_to_quaternion verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("axis_angle_to_quaternion verification failed");
        $finish;
    end

endmodule

[files.f]
sv/aaq_pkg.sv
sv/aaq_in_if.sv
sv/aaq_out_if.sv
sv/aaq_skid.sv
sv/axis_angle_to_quaternion.sv
dv/aaq_checker.sv
dv/testbench.sv
